// ===== hdl/pcpfa_pkg.sv =====
package pcpfa_pkg;

    localparam int CPU_MAX_W = 6;
    localparam int IDX_MAX_W = 20;
    localparam int CNT_W     = 32;

    localparam logic       CMD_ALLOC      = 1'b0;
    localparam logic       CMD_FREE       = 1'b1;
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_OOM       = 2'd1;
    localparam logic [1:0] STAT_REJECT    = 2'd2;
    localparam logic       REG_POOL_START = 1'b0;
    localparam logic       REG_POOL_END   = 1'b1;

    typedef struct packed {
        logic        command;
        logic [2:0]  cpu_id;
        logic [31:0] free_address;
    } req_t;

    typedef struct packed {
        logic [31:0] page_address;
        logic [1:0]  status;
    } rsp_t;

    // classified command between front and back
    typedef struct packed {
        logic                 is_free;
        logic                 bad;
        logic [CPU_MAX_W-1:0] cpu;
        logic [IDX_MAX_W-1:0] idx;
    } cmd_t;

endpackage

// ===== hdl/pcpfa_front.sv =====
module pcpfa_front #(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  pcpfa_pkg::req_t    req,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output logic [32:0]        base,
    output logic               cmd_valid,
    output pcpfa_pkg::cmd_t    cmd,
    input  logic               cmd_take
);
    import pcpfa_pkg::*;

    localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int OFF_W = $clog2(PAGE_BYTES);
    localparam logic [32:0] OFF_MASK = 33'(PAGE_BYTES - 1);

    logic [31:0] pool_start_reg, pool_end_reg;
    logic [32:0] base_reg, base_next;
    cmd_t        q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        cls;
    logic [6:0]  cpu_m;
    logic [31:0] diff, idx_full;
    logic        accept;

    assign base_next = ({1'b0, cfg_data} + OFF_MASK) & ~OFF_MASK;

    always_comb
    begin
        cpu_m = {4'd0, req.cpu_id};
        for (int i = 0; i < 4; i++)
        begin
            if (cpu_m >= 7'(CPUS))
                cpu_m = cpu_m - 7'(CPUS);
        end
        diff     = req.free_address - base_reg[31:0];
        idx_full = diff >> OFF_W;
        cls.is_free = (req.command == CMD_FREE);
        cls.cpu     = cpu_m[CPU_MAX_W-1:0];
        cls.idx     = IDX_MAX_W'(idx_full[IDX_W-1:0]);
        cls.bad     = ((33'(req.free_address) & OFF_MASK) != 33'd0)
                   || (req.free_address < pool_start_reg)
                   || (req.free_address >= pool_end_reg)
                   || ({1'b0, req.free_address} < base_reg)
                   || (idx_full >= 32'(PAGES));
    end

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign base      = base_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !cmd_take)
            cnt_next = cnt_reg + 2'd1;
        else if (!accept && cmd_take)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_start_reg <= '0;
            pool_end_reg   <= '0;
            base_reg       <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_POOL_START)
            begin
                pool_start_reg <= cfg_data;
                base_reg       <= base_next;
            end
            if (cfg_valid && cfg_index == REG_POOL_END)
                pool_end_reg <= cfg_data;
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (cmd_take)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== hdl/pcpfa_back.sv =====
module pcpfa_back #(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [32:0]        base,
    input  logic               cmd_valid,
    input  pcpfa_pkg::cmd_t    cmd,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output pcpfa_pkg::rsp_t    rsp
);
    import pcpfa_pkg::*;

    localparam int IDX_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CPU_W = (CPUS > 1) ? $clog2(CPUS) : 1;
    localparam int OFF_W = $clog2(PAGE_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_POP  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_WALK = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] heads_reg [CPUS];
    logic [IDX_W-1:0] heads_next [CPUS];
    logic [CNT_W-1:0] counts_reg [CPUS];
    logic [CNT_W-1:0] counts_next [CPUS];
    logic [CPU_W-1:0] cpu_reg, cpu_next, vic_reg, vic_next, sel;
    logic [IDX_W-1:0] first_reg, first_next, fnext_reg, fnext_next, fn;
    logic [CNT_W-1:0] take_reg, take_next, k_reg, k_next, n_reg, n_next;
    logic             fcyc_reg, fcyc_next;
    logic [IDX_W-1:0] head_rd;
    logic [CNT_W-1:0] cnt_rd;
    logic [CPU_W-1:0] c_cpu;
    logic [IDX_W-1:0] c_idx;

    logic [IDX_W-1:0] link_mem [PAGES];
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_wa, mem_wd, mem_ra, rd_q;

    rsp_t             res_reg [2];
    logic             res_wr_reg, res_rd_reg;
    logic [1:0]       res_cnt_reg, res_cnt_next;
    logic             res_we;
    rsp_t             res_d;

    assign c_cpu   = cmd.cpu[CPU_W-1:0];
    assign c_idx   = cmd.idx[IDX_W-1:0];
    assign sel     = (state_reg == ST_IDLE) ? c_cpu : vic_reg;
    assign head_rd = heads_reg[sel];
    assign cnt_rd  = counts_reg[sel];
    assign fn      = fcyc_reg ? rd_q : fnext_reg;

    assign empty = (res_cnt_reg == 2'd0);
    assign rsp   = res_reg[res_rd_reg];

    always_comb
    begin
        state_next = state_reg;
        heads_next = heads_reg;
        counts_next = counts_reg;
        cpu_next   = cpu_reg;
        vic_next   = vic_reg;
        first_next = first_reg;
        fnext_next = fnext_reg;
        take_next  = take_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        fcyc_next  = fcyc_reg;
        cmd_take   = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_wa     = c_idx;
        mem_wd     = head_rd;
        mem_ra     = head_rd;
        res_we     = 1'b0;
        res_d      = '{page_address: 32'd0, status: STAT_DONE};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && res_cnt_reg != 2'd2)
                begin
                    cmd_take = 1'b1;
                    cpu_next = c_cpu;
                    if (cmd.is_free)
                    begin
                        res_we = 1'b1;
                        if (cmd.bad)
                            res_d.status = STAT_REJECT;
                        else
                        begin
                            mem_we = 1'b1;
                            heads_next[c_cpu]  = c_idx;
                            counts_next[c_cpu] = cnt_rd + CNT_W'(1);
                        end
                    end
                    else if (cnt_rd != '0)
                    begin
                        mem_re     = 1'b1;
                        first_next = head_rd;
                        state_next = ST_POP;
                    end
                    else
                    begin
                        vic_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_POP:
            begin
                heads_next[cpu_reg]  = rd_q;
                counts_next[cpu_reg] = counts_reg[cpu_reg] - CNT_W'(1);
                res_we = 1'b1;
                res_d.page_address = base[31:0] + (32'(first_reg) << OFF_W);
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (vic_reg != cpu_reg && cnt_rd != '0)
                begin
                    n_next     = cnt_rd;
                    take_next  = (cnt_rd >> 1) + CNT_W'(1);
                    k_next     = CNT_W'(1);
                    first_next = head_rd;
                    mem_re     = 1'b1;
                    fcyc_next  = 1'b1;
                    state_next = ST_WALK;
                end
                else if (vic_reg == CPU_W'(CPUS - 1))
                begin
                    res_we       = 1'b1;
                    res_d.status = STAT_OOM;
                    state_next   = ST_IDLE;
                end
                else
                    vic_next = vic_reg + CPU_W'(1);
            end
            ST_WALK:
            begin
                fcyc_next  = 1'b0;
                fnext_next = fn;
                if (k_reg < take_reg)
                begin
                    // advance the tail of the stolen run
                    k_next = k_reg + CNT_W'(1);
                    mem_re = 1'b1;
                    mem_ra = rd_q;
                end
                else
                begin
                    heads_next[vic_reg]  = rd_q;
                    counts_next[vic_reg] = n_reg - take_reg;
                    heads_next[cpu_reg]  = fn;
                    counts_next[cpu_reg] = take_reg - CNT_W'(1);
                    res_we = 1'b1;
                    res_d.page_address = base[31:0] + (32'(first_reg) << OFF_W);
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (res_we && !(pop && !empty))
            res_cnt_next = res_cnt_reg + 2'd1;
        else if (!res_we && pop && !empty)
            res_cnt_next = res_cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
            for (int i = 0; i < CPUS; i++)
            begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            heads_reg   <= heads_next;
            counts_reg  <= counts_next;
            res_cnt_reg <= res_cnt_next;
            if (res_we)
                res_wr_reg <= !res_wr_reg;
            if (pop && !empty)
                res_rd_reg <= !res_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cpu_reg   <= cpu_next;
        vic_reg   <= vic_next;
        first_reg <= first_next;
        fnext_reg <= fnext_next;
        take_reg  <= take_next;
        k_reg     <= k_next;
        n_reg     <= n_next;
        fcyc_reg  <= fcyc_next;
        if (res_we)
            res_reg[res_wr_reg] <= res_d;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_q <= link_mem[mem_ra];
    end

endmodule

// ===== hdl/per_cpu_page_free_list_allocator_unit.sv =====
// A free is answered straight from the idle state, a local allocate reads
// the next link in ST_POP, and a steal scans the other CPUs' lists in ST_SCAN
// and then walks floor(n/2)+1 links of the victim list in ST_WALK, one link
// read per cycle on the link memory read port. A steal holds the back end.
// Reset (rst_n, asynchronous, low): all lists empty, pool registers 0,
// both queues empty; link memory is not cleared.
module per_cpu_page_free_list_allocator_unit #(
    parameter int CPUS       = 8,
    parameter int PAGES      = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pcpfa_pkg::req_t  req,
    output logic             empty,
    input  logic             pop,
    output pcpfa_pkg::rsp_t  rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [31:0]      cfg_data
);
    import pcpfa_pkg::*;

    logic [32:0] base;
    logic        cmd_valid, cmd_take;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    pcpfa_front #(.CPUS(CPUS), .PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .base      (base),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    pcpfa_back #(.CPUS(CPUS), .PAGES(PAGES), .PAGE_BYTES(PAGE_BYTES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .base      (base),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/pcpfa_checker.sv =====
module pcpfa_props (
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input pcpfa_pkg::rsp_t rsp
);
    import pcpfa_pkg::*;

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (rsp.status == STAT_DONE || rsp.status == STAT_OOM
                    || rsp.status == STAT_REJECT))
        else $error("illegal status code");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rsp.status != STAT_DONE) |-> rsp.page_address == 32'd0)
        else $error("failed beat carries an address");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(rsp)))
        else $error("waiting result changed");

endmodule

bind per_cpu_page_free_list_allocator_unit pcpfa_props u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);
